[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/srfc_pkg.sv]
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared types, constants and the CRC-16 byte update of the response checker.
// ----------------------------------------------------------------------------
`default_nettype none

package srfc_pkg;

   localparam int DEF_MAX_PAYLOAD = 8;

   localparam logic [7:0]  FUNC_READ = 8'h03;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   localparam int READING_W = 17;
   localparam int CFG_LEN_W = 4;
   localparam int CFG_MODE_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE    = 2'd1;

   localparam logic [CFG_MODE_W-1:0] MODE_HUMIDITY    = 2'd1;
   localparam logic [CFG_MODE_W-1:0] MODE_TEMPERATURE = 2'd2;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_HDR = 2'd1,
      ST_CRC = 2'd2
   } status_type;

   // frame-end report from the parser to the output buffer
   typedef struct packed {
      logic                        done;
      logic                        at_end;
      status_type                  status;
      logic signed [READING_W-1:0] reading;
   } srfc_done_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i,
                                            input logic [7:0]  data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/core/srfc_parser.sv]
// ----------------------------------------------------------------------------
// srfc_parser
// Byte-wise frame tracker: header check, CRC-16 update, payload capture and
// the frame-end verdict with the decoded reading.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_parser
   import srfc_pkg::*;
#(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1),
   localparam int POS_W = $clog2(MAX_PAYLOAD + 4),
   localparam int IDX_W = $clog2(MAX_PAYLOAD)
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  wire  [7:0]             rx_byte,
   input  wire                    frame_start,
   input  wire  [CFG_LEN_W-1:0]   payload_length,
   input  wire  [CFG_MODE_W-1:0]  decode_mode,
   output logic [LEN_W-1:0]       eff_len,
   output logic [7:0]             store [MAX_PAYLOAD],
   output srfc_done_type          report
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic             hg_ff, hg_in;
   logic [7:0]       crclo_ff, crclo_in;
   logic [7:0]       store_ff [MAX_PAYLOAD];

   logic [POS_W-1:0] pos;
   logic [15:0]      crc;
   logic             hg;
   logic [7:0]       crclo;
   logic [POS_W-1:0] len_p;
   logic             in_data;
   logic             in_crclo;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [15:0]      raw;
   logic signed [READING_W-1:0] mag;

   // 0 acts as 1, anything above the store depth acts as the depth
   always_comb begin
      if (payload_length == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(payload_length) > 32'(MAX_PAYLOAD)) begin
         eff_len = LEN_W'(MAX_PAYLOAD);
      end else begin
         eff_len = LEN_W'(payload_length);
      end
   end

   assign len_p = POS_W'(eff_len);

   always_comb begin
      pos   = frame_start ? '0 : pos_ff;
      crc   = frame_start ? CRC_INIT : crc_ff;
      hg    = frame_start ? 1'b1 : hg_ff;
      crclo = frame_start ? 8'h00 : crclo_ff;

      in_data  = pos < (len_p + POS_W'(2));
      in_crclo = pos == (len_p + POS_W'(2));
      wr_idx   = IDX_W'(pos - POS_W'(2));
      wr_en    = accept && in_data && (pos >= POS_W'(2));

      pos_in   = pos_ff;
      crc_in   = crc_ff;
      hg_in    = hg_ff;
      crclo_in = crclo_ff;
      report   = '0;
      report.at_end = pos_ff >= (len_p + POS_W'(3));

      raw = {store_ff[0], store_ff[1]};
      mag = READING_W'(raw[14:0]);

      if (accept) begin
         if (in_data) begin
            crc_in = crc_byte(crc, rx_byte);
            hg_in  = hg;
            if (pos == '0 && rx_byte != FUNC_READ) begin
               hg_in = 1'b0;
            end
            if (pos == POS_W'(1) && rx_byte != 8'(eff_len)) begin
               hg_in = 1'b0;
            end
            pos_in   = pos + POS_W'(1);
            crclo_in = crclo;
         end else if (in_crclo) begin
            crc_in   = crc;
            hg_in    = hg;
            crclo_in = rx_byte;
            pos_in   = pos + POS_W'(1);
         end else begin
            report.done = 1'b1;
            if (!hg) begin
               report.status = ST_HDR;
            end else if ({rx_byte, crclo} != crc) begin
               report.status = ST_CRC;
            end else begin
               report.status = ST_OK;
               if (eff_len >= LEN_W'(2)) begin
                  if (decode_mode == MODE_HUMIDITY) begin
                     report.reading = READING_W'(raw);
                  end else if (decode_mode == MODE_TEMPERATURE) begin
                     report.reading = raw[15] ? -mag : READING_W'(raw);
                  end
               end
            end
            pos_in   = '0;
            crc_in   = CRC_INIT;
            hg_in    = 1'b1;
            crclo_in = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         crc_ff   <= CRC_INIT;
         hg_ff    <= 1'b1;
         crclo_ff <= 8'h00;
      end else begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         hg_ff    <= hg_in;
         crclo_ff <= crclo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= rx_byte;
      end
   end

   assign store = store_ff;

endmodule

`default_nettype wire

[rtl/core/sensor_response_frame_checker_core.sv]
// ----------------------------------------------------------------------------
// sensor_response_frame_checker_core
// Latency: results of a frame appear the cycle after its last CRC byte.
// Throughput: one byte per cycle; results drain at one item per cycle from the
// output buffer while rsp_tready is high. A frame end stalls input only while the
// previous frame's results are still draining. Reset is synchronous and active high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sensor_response_frame_checker_core
   import srfc_pkg::*;
#(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  wire                    clock,
   input  wire                    reset,
   // stream in
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [7:0]             req_tdata,   // [7:0] rx_byte
   input  wire                    req_tuser,   // [0] frame_start
   // stream out
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [31:0]            rsp_tdata,   // [7:0] payload_byte, [9:8] status,
                                               // [26:10] reading, [31:27] zero
   output logic                   rsp_tlast,   // last
   // register writes
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_data
);

   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam int IDX_W = $clog2(MAX_PAYLOAD);

   logic [CFG_LEN_W-1:0]  len_cfg_ff;
   logic [CFG_MODE_W-1:0] mode_cfg_ff;

   logic                  accept;
   logic [LEN_W-1:0]      eff_len;
   logic [7:0]            store [MAX_PAYLOAD];
   srfc_done_type         report;

   logic [7:0]            buf_ff [MAX_PAYLOAD];
   logic                  busy_ff, busy_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [LEN_W-1:0]      cnt_ff;
   status_type            status_ff;
   logic signed [READING_W-1:0] reading_ff;

   logic                  is_last;
   logic                  rsp_xfer;

   // ---- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff  <= CFG_LEN_W'(2);
         mode_cfg_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_PAYLOAD_LENGTH) begin
            len_cfg_ff <= csr_data[CFG_LEN_W-1:0];
         end else if (csr_index == CSR_DECODE_MODE) begin
            mode_cfg_ff <= csr_data[CFG_MODE_W-1:0];
         end
      end
   end

   // ---- parser
   assign req_tready = !(busy_ff && report.at_end);
   assign accept     = req_tvalid && req_tready;

   srfc_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .rx_byte        (req_tdata),
      .frame_start    (req_tuser),
      .payload_length (len_cfg_ff),
      .decode_mode    (mode_cfg_ff),
      .eff_len        (eff_len),
      .store          (store),
      .report         (report)
   );

   // ---- output buffer
   assign is_last  = (LEN_W'(idx_ff) + LEN_W'(1)) == cnt_ff;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (report.done) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (rsp_xfer) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (report.done) begin
         buf_ff     <= store;
         cnt_ff     <= (report.status == ST_OK) ? eff_len : LEN_W'(1);
         status_ff  <= report.status;
         reading_ff <= report.reading;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = is_last;

   always_comb begin
      rsp_tdata        = '0;
      rsp_tdata[7:0]   = (status_ff == ST_OK) ? buf_ff[idx_ff] : 8'h00;
      rsp_tdata[9:8]   = status_ff;
      rsp_tdata[26:10] = is_last ? reading_ff : '0;
   end

   // ---- checks
   `ASSERT_IMPLIES(a_no_load_busy, clock, reset, busy_ff, !report.done,
                   "frame end while results still pending")
   `ASSERT_IMPLIES(a_idx_range, clock, reset, busy_ff, LEN_W'(idx_ff) < cnt_ff,
                   "drain index past item count")
   `ASSERT_IMPLIES(a_err_single, clock, reset, busy_ff && status_ff != ST_OK,
                   cnt_ff == LEN_W'(1), "error frame with more than one item")
   `ASSERT_NEXT(a_drain_cont, clock, reset, rsp_xfer && !rsp_tlast, busy_ff,
                "drain stopped before last item")

endmodule

`default_nettype wire

[sim/srfc_response_checker.sv]
// ----------------------------------------------------------------------------
// srfc_response_checker
// Watches the byte stream, register writes and result stream of the response
// frame checker. It tracks the frame parser and CRC on its own and checks
// each result transfer against the oldest outstanding readout.
// ----------------------------------------------------------------------------
module srfc_response_checker
   import srfc_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   input  wire                   req_tready,
   input  wire  [7:0]            req_tdata,   // [7:0] rx_byte
   input  wire                   req_tuser,   // [0] frame_start
   input  wire                   rsp_tvalid,
   input  wire                   rsp_tready,
   input  wire  [31:0]           rsp_tdata,   // [7:0] payload_byte, [9:8] status,
                                              // [26:10] reading, [31:27] zero
   input  wire                   rsp_tlast,   // last
   input  wire                   csr_valid,
   input  wire                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = DEF_MAX_PAYLOAD;

   typedef struct {
      logic [7:0]                  data;
      status_type                  status;
      logic signed [READING_W-1:0] reading;
      logic                        last;
   } readout_type;

   readout_type          expected_readouts[$];

   logic [CFG_LEN_W-1:0]  len_reg;
   logic [CFG_MODE_W-1:0] mode_reg;
   int                    frame_pos;
   logic [15:0]           crc_run;
   logic                  header_ok;
   logic [7:0]            crc_lsb;
   logic [7:0]            payload_mem [STORE_DEPTH];

   // out-of-range lengths clamp to 1..STORE_DEPTH
   function automatic int frame_len();
      int n;
      n = len_reg;
      if (n == 0) n = 1;
      if (n > STORE_DEPTH) n = STORE_DEPTH;
      return n;
   endfunction

   function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] acc;
      acc = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

   function automatic void check_field(input string what, input logic signed [31:0] want,
                                       input logic signed [31:0] seen);
      if (seen !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
      end
   endfunction

   task automatic restart_frame();
      frame_pos = 0;
      crc_run   = CRC_INIT;
      header_ok = 1'b1;
      crc_lsb   = 8'h00;
   endtask

   task automatic queue_readout(input logic [7:0] data, input status_type status,
                                input logic signed [READING_W-1:0] reading,
                                input logic last);
      readout_type r;
      r.data    = data;
      r.status  = status;
      r.reading = reading;
      r.last    = last;
      expected_readouts.push_back(r);
   endtask

   task automatic absorb_rx_byte(input logic [7:0] b, input logic start);
      int                          n;
      logic [15:0]                 got_crc;
      logic [15:0]                 raw;
      logic signed [READING_W-1:0] value;
      n = frame_len();
      if (start) restart_frame();
      if (frame_pos < n + 2) begin
         crc_run = crc16_fold(crc_run, b);
         if (frame_pos == 0 && b != FUNC_READ) header_ok = 1'b0;
         if (frame_pos == 1 && b != 8'(n)) header_ok = 1'b0;
         if (frame_pos >= 2) payload_mem[frame_pos - 2] = b;
         frame_pos++;
      end else if (frame_pos == n + 2) begin
         crc_lsb = b;
         frame_pos++;
      end else begin
         // CRC high byte (or anything past it) closes the frame
         got_crc = {b, crc_lsb};
         if (!header_ok) begin
            queue_readout(8'h00, ST_HDR, '0, 1'b1);
         end else if (got_crc != crc_run) begin
            queue_readout(8'h00, ST_CRC, '0, 1'b1);
         end else begin
            raw   = {payload_mem[0], payload_mem[1]};
            value = '0;
            if (n >= 2 && mode_reg == MODE_HUMIDITY) begin
               value = {1'b0, raw};
            end else if (n >= 2 && mode_reg == MODE_TEMPERATURE) begin
               // sign-magnitude: bit 15 is the sign
               value = raw[15] ? -{2'b00, raw[14:0]} : {1'b0, raw};
            end
            for (int i = 0; i < n; i++) begin
               queue_readout(payload_mem[i], ST_OK, (i == n - 1) ? value : '0, i == n - 1);
            end
         end
         restart_frame();
      end
   endtask

   always @(posedge clock) begin
      readout_type                 want;
      logic signed [READING_W-1:0] seen_reading;
      if (reset) begin
         fail_count = 0;
         len_reg    = 4'd2;
         mode_reg   = '0;
         expected_readouts.delete();
         foreach (payload_mem[i]) payload_mem[i] = 8'h00;
         restart_frame();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PAYLOAD_LENGTH: len_reg  = csr_data[CFG_LEN_W-1:0];
               CSR_DECODE_MODE:    mode_reg = csr_data[CFG_MODE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readouts.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result transfer, expected none, got tdata %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want         = expected_readouts.pop_front();
               seen_reading = rsp_tdata[26:10];
               check_field("payload_byte", want.data, rsp_tdata[7:0]);
               check_field("status", want.status, rsp_tdata[9:8]);
               check_field("reading", want.reading, seen_reading);
               check_field("last", want.last, rsp_tlast);
               check_field("tdata padding", 0, rsp_tdata[31:27]);
            end
         end
         if (req_tvalid && req_tready) absorb_rx_byte(req_tdata, req_tuser);
      end
      pending <= expected_readouts.size();
   end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sensor response frame checker: directed frames for length
// clamping, decode modes, error priority and a length change inside a frame,
// then random phases of well-formed, corrupted, cut-off and noise frames with
// random idle on both streams. Checking is done in srfc_response_checker.
// ----------------------------------------------------------------------------
module tb
   import srfc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 1000;
   localparam int PHASES      = 6;
   localparam int PHASE_BYTES = 34;

   localparam logic [CFG_MODE_W-1:0] MODE_UNDEFINED = 2'd3;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   int                    fail_count;
   int                    pending;

   logic                  calm       = 1'b0;
   logic [CFG_LEN_W-1:0]  cur_len    = 4'd2;
   logic [7:0]            pay_buf [DEF_MAX_PAYLOAD];
   int                    bytes_sent = 0;
   int                    stall_left = 0;
   int                    idle_cycles = 0;

   sensor_response_frame_checker_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   srfc_response_checker frame_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
   endfunction

   function automatic int active_len();
      int n;
      n = cur_len;
      if (n == 0) n = 1;
      if (n > DEF_MAX_PAYLOAD) n = DEF_MAX_PAYLOAD;
      return n;
   endfunction

   function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] acc;
      acc = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         stall_left = idle_len() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic start);
      if (!calm && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         repeat (idle_len()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_LEN_W-1:0] len, input logic [CFG_MODE_W-1:0] mode);
      write_reg(CSR_PAYLOAD_LENGTH, len);
      write_reg(CSR_DECODE_MODE, CSR_DATA_W'(mode));
      csr_valid <= 1'b0;
      cur_len = len;
   endtask

   // wait for all readouts, then let the core go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // sends the first 'keep' bytes of: func, count, payload, CRC low, CRC high
   task automatic send_frame(input logic [7:0] func, input logic [7:0] count,
                             input logic start, input logic [15:0] crc_mask, input int keep);
      logic [7:0]  frame_bytes [DEF_MAX_PAYLOAD + 4];
      logic [15:0] c;
      int          n;
      n = active_len();
      frame_bytes[0] = func;
      frame_bytes[1] = count;
      for (int i = 0; i < n; i++) frame_bytes[i + 2] = pay_buf[i];
      c = CRC_INIT;
      for (int i = 0; i < n + 2; i++) c = crc16_next(c, frame_bytes[i]);
      c = c ^ crc_mask;
      frame_bytes[n + 2] = c[7:0];
      frame_bytes[n + 3] = c[15:8];
      for (int i = 0; i < keep; i++) push_byte(frame_bytes[i], (i == 0) ? start : 1'b0);
   endtask

   initial begin
      int                   r;
      int                   n;
      int                   mark;
      logic                 synced;
      logic                 first;
      logic [15:0]          c;
      logic [15:0]          mask;
      logic [CFG_LEN_W-1:0] len;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // over-long length clamps to 8; this frame also fills every store entry
      configure(4'd15, MODE_TEMPERATURE);
      pay_buf = '{8'hFF, 8'hFF, 8'h00, 8'h7F, 8'h80, 8'h01, 8'h55, 8'hAA};
      send_frame(FUNC_READ, 8'd8, 1'b1, 16'h0000, 12);
      settle();

      // zero length acts as one; decode yields zero; no frame_start after a frame
      configure(4'd0, MODE_HUMIDITY);
      pay_buf[0] = 8'h00;
      send_frame(FUNC_READ, 8'd1, 1'b0, 16'h0000, 5);
      settle();

      // bad function code and bad CRC together: header error wins
      configure(4'd2, MODE_UNDEFINED);
      pay_buf[0] = 8'h80;
      pay_buf[1] = 8'h00;
      send_frame(8'h04, 8'd2, 1'b0, 16'h0101, 6);
      send_frame(FUNC_READ, 8'd2, 1'b0, 16'h0000, 6);
      settle();

      // length grows from one to two after the first payload byte
      configure(4'd1, MODE_HUMIDITY);
      pay_buf[0] = 8'hFF;
      send_frame(FUNC_READ, 8'd1, 1'b1, 16'h0000, 3);
      settle();
      configure(4'd2, MODE_HUMIDITY);
      c = crc16_next(CRC_INIT, FUNC_READ);
      c = crc16_next(c, 8'd1);
      c = crc16_next(c, 8'hFF);
      c = crc16_next(c, 8'hFF);
      push_byte(8'hFF, 1'b0);
      push_byte(c[7:0], 1'b0);
      push_byte(c[15:8], 1'b0);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         if ($urandom_range(0, 99) < 40) begin
            case ($urandom_range(0, 3))
               0:       len = 4'd0;
               1:       len = 4'd1;
               2:       len = 4'd8;
               default: len = 4'd15;
            endcase
         end else begin
            len = CFG_LEN_W'($urandom_range(0, 15));
         end
         configure(len, CFG_MODE_W'($urandom_range(0, 3)));
         calm   = ($urandom_range(0, 3) == 0);
         synced = 1'b0;
         mark   = bytes_sent;
         while (bytes_sent - mark < PHASE_BYTES) begin
            n = active_len();
            foreach (pay_buf[i]) pay_buf[i] = 8'($urandom_range(0, 255));
            first = synced ? 1'($urandom_range(0, 1)) : 1'b1;
            r = $urandom_range(0, 99);
            if (r < 65) begin
               send_frame(FUNC_READ, 8'(n), first, 16'h0000, n + 4);
               synced = 1'b1;
            end else if (r < 75) begin
               send_frame(FUNC_READ, 8'(n), first, 16'($urandom_range(1, 65535)), n + 4);
               synced = 1'b1;
            end else if (r < 82) begin
               mask = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom_range(1, 65535));
               send_frame(FUNC_READ ^ 8'($urandom_range(1, 255)), 8'(n), first, mask, n + 4);
               synced = 1'b1;
            end else if (r < 89) begin
               send_frame(FUNC_READ, 8'(n) ^ 8'($urandom_range(1, 255)), first, 16'h0000, n + 4);
               synced = 1'b1;
            end else if (r < 95) begin
               // cut-off frame; the next one must resync with frame_start
               send_frame(FUNC_READ, 8'(n), first, 16'h0000, $urandom_range(1, n + 3));
               synced = 1'b0;
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               end
               synced = 1'b0;
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[sensor_response_frame_checker_core.f]
+incdir+rtl/core
rtl/core/srfc_pkg.sv
rtl/core/srfc_parser.sv
rtl/core/sensor_response_frame_checker_core.sv
sim/srfc_response_checker.sv
sim/tb.sv
